// ----- hdl/ptd_pkg.sv -----
`default_nettype none

package ptd_pkg;

	// input opcodes
	localparam logic [1:0] OPC_TICK = 2'd0;
	localparam logic [1:0] OPC_REG  = 2'd1;
	localparam logic [1:0] OPC_RPT  = 2'd2;

	// result kinds
	localparam logic [1:0] KIND_DISPATCH = 2'd0;
	localparam logic [1:0] KIND_SUMMARY  = 2'd1;
	localparam logic [1:0] KIND_REGISTER = 2'd2;
	localparam logic [1:0] KIND_VERDICT  = 2'd3;

	// period = PERIOD_NUM / frequency, both DIV_W bits wide
	localparam int unsigned DIV_W = 20;
	localparam logic [DIV_W-1:0] PERIOD_NUM = 20'd1000000;

	// command classes handed from front to back
	typedef enum logic [1:0] {
		OP_TICK,
		OP_REG,
		OP_RPT
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t     op;
		logic        zero_freq;
		logic [63:0] now_us;
		logic [19:0] rate_hz;
		logic [31:0] budget_us;
		logic [2:0]  task_index;
		logic [31:0] used_us;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [2:0]  slot;
		logic [63:0] lag_us;
		logic [63:0] wake_at_us;
		logic        idle;
		logic        accepted;
		logic        overrun;
		logic        last;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DEC,
		ST_DIV,
		ST_ADD,
		ST_EVAL,
		ST_RPT,
		ST_SUM
	} state_t;

endpackage

`default_nettype wire

// ----- hdl/periodic_task_dispatcher.sv -----
// Channel   Dir  Group              Contents
// command   in   s_axis_t*          tuser opcode; tdata now, frequency, deadline, index, runtime
// result    out  m_axis_t*          tuser kind; tdata slot, jitter, next wake, flags; tlast
//
// A tick does one table read, add and compare per registered task in the back
// end. A registration waits on the one-bit-per-cycle period divider; a runtime report
// does one table read and compare (neither for an empty slot). The front stage and the
// two-entry queue register each command and keep accepting, until the queue is full,
// while the back end works or the result register waits on m_axis_tready.
// Reset clears the task count and all handshake state; table contents are not cleared.
`default_nettype none

module periodic_task_dispatcher #(
	parameter int unsigned TASK_SLOTS = 8
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// [63:0] now_us, [83:64] rate_hz, [115:84] budget_us,
	// [118:116] task_index, [150:119] used_us, [151] zero
	input  wire logic [151:0] s_axis_tdata,
	// [1:0] opcode
	input  wire logic [1:0]   s_axis_tuser,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// [2:0] slot, [66:3] lag_us, [130:67] wake_at_us, [131] idle,
	// [132] accepted, [133] overrun, [135:134] zero
	output logic [135:0]      m_axis_tdata,
	// [1:0] kind
	output logic [1:0]        m_axis_tuser,
	output logic              m_axis_tlast
);

	logic             push;
	logic             full;
	logic             pop;
	logic             q_valid;
	ptd_pkg::cmd_t    push_data;
	ptd_pkg::cmd_t    q_data;
	ptd_pkg::result_t res;

	ptd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.opcode     (s_axis_tuser),
		.now_us     (s_axis_tdata[63:0]),
		.rate_hz    (s_axis_tdata[83:64]),
		.budget_us  (s_axis_tdata[115:84]),
		.task_index (s_axis_tdata[118:116]),
		.used_us    (s_axis_tdata[150:119]),
		.push       (push),
		.push_data  (push_data),
		.full       (full)
	);

	ptd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.valid     (q_valid),
		.pop_data  (q_data)
	);

	ptd_back #(
		.TASK_SLOTS (TASK_SLOTS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (q_valid),
		.cmd       (q_data),
		.cmd_pop   (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (res)
	);

	assign m_axis_tdata = {2'b00, res.overrun, res.accepted, res.idle,
		res.wake_at_us, res.lag_us, res.slot};
	assign m_axis_tuser = res.kind;
	assign m_axis_tlast = res.last;

endmodule

`default_nettype wire

// ----- hdl/ptd_div.sv -----
`default_nettype none

// Restoring divider: PERIOD_NUM / divisor, one quotient bit per cycle.
module ptd_div (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic [ptd_pkg::DIV_W-1:0] divisor,
	output logic                          done,
	output logic [ptd_pkg::DIV_W-1:0]     quotient
);

	localparam int unsigned W  = ptd_pkg::DIV_W;
	localparam int unsigned CW = $clog2(W);

	logic          run_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  div_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  quo_q;
	logic [W:0]    trial;
	logic          fits;

	assign trial = {rem_q, quo_q[W-1]};
	assign fits  = trial >= {1'b0, div_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (run_q) begin
			cnt_q <= cnt_q + CW'(1);
			if (cnt_q == CW'(W - 1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// datapath: dividend shifts out of quo_q while quotient bits shift in
	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= divisor;
			rem_q <= '0;
			quo_q <= ptd_pkg::PERIOD_NUM;
		end else if (run_q) begin
			if (fits) begin
				rem_q <= W'(trial - {1'b0, div_q});
			end else begin
				rem_q <= W'(trial);
			end
			quo_q <= {quo_q[W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

// ----- hdl/ptd_fifo.sv -----
`default_nettype none

// Two-entry command queue between front and back.
module ptd_fifo (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire ptd_pkg::cmd_t push_data,
	output logic               full,
	input  wire logic          pop,
	output logic               valid,
	output ptd_pkg::cmd_t      pop_data
);

	ptd_pkg::cmd_t ent_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] cnt_q;

	assign full     = cnt_q == 2'd2;
	assign valid    = cnt_q != 2'd0;
	assign pop_data = ent_q[rptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (pop) begin
				rptr_q <= ~rptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

// ----- hdl/ptd_front.sv -----
`default_nettype none

// Input stage: takes transactions, classifies opcodes, drops unused ones.
module ptd_front (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire logic [1:0]   opcode,
	input  wire logic [63:0]  now_us,
	input  wire logic [19:0]  rate_hz,
	input  wire logic [31:0]  budget_us,
	input  wire logic [2:0]   task_index,
	input  wire logic [31:0]  used_us,
	output logic              push,
	output ptd_pkg::cmd_t     push_data,
	input  wire logic         full
);

	logic          valid_s1;
	ptd_pkg::cmd_t cmd_s1;
	ptd_pkg::cmd_t cmd;
	logic          known;

	// classify
	always_comb begin
		cmd            = '0;
		known          = 1'b1;
		cmd.now_us     = now_us;
		cmd.rate_hz    = rate_hz;
		cmd.budget_us  = budget_us;
		cmd.task_index = task_index;
		cmd.used_us    = used_us;
		cmd.zero_freq  = rate_hz == '0;
		unique case (opcode)
			ptd_pkg::OPC_TICK: cmd.op = ptd_pkg::OP_TICK;
			ptd_pkg::OPC_REG:  cmd.op = ptd_pkg::OP_REG;
			ptd_pkg::OPC_RPT:  cmd.op = ptd_pkg::OP_RPT;
			default: begin
				cmd.op = ptd_pkg::OP_TICK;
				known  = 1'b0;
			end
		endcase
	end

	assign in_ready  = !valid_s1 || !full;
	assign push      = valid_s1 && !full;
	assign push_data = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid && known;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1 <= cmd;
		end
	end

endmodule

`default_nettype wire

// ----- hdl/ptd_back.sv -----
`default_nettype none

// Execution sequencer: task tables, scan, registration and verdicts.
module ptd_back #(
	parameter int unsigned TASK_SLOTS = 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cmd_valid,
	input  wire ptd_pkg::cmd_t cmd,
	output logic               cmd_pop,
	output logic               out_valid,
	input  wire logic          out_ready,
	output ptd_pkg::result_t   out_res
);

	localparam int unsigned AW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
	localparam int unsigned CW = $clog2(TASK_SLOTS + 1);
	localparam int unsigned XW = (CW > 3) ? CW : 3;

	// task tables
	logic [19:0] period_mem   [TASK_SLOTS];
	logic [31:0] deadline_mem [TASK_SLOTS];
	logic [63:0] last_mem     [TASK_SLOTS];

	ptd_pkg::state_t  state_q, state_d;
	ptd_pkg::cmd_t    cur_q;
	ptd_pkg::result_t out_q, res;

	logic          out_valid_q;
	logic          out_free;
	logic          emit;
	logic [CW-1:0] cnt_q;
	logic [AW-1:0] i_q;
	logic [63:0]   next_q;
	logic          idle_q;
	logic [63:0]   due_q;
	logic [19:0]   period_q;
	logic [19:0]   period_rd_q;
	logic [31:0]   deadline_rd_q;
	logic [63:0]   last_rd_q;

	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic          wr_reg;
	logic          wr_last;
	logic          adv;
	logic          div_start;
	logic          div_done;
	logic [19:0]   quotient;

	logic          is_due;
	logic          resync;
	logic          last_slot;
	logic          in_range;
	logic          full;
	logic [63:0]   last_wr_val;

	ptd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.divisor  (cur_q.rate_hz),
		.done     (div_done),
		.quotient (quotient)
	);

	assign out_free    = !out_valid_q || out_ready;
	assign is_due      = cur_q.now_us >= due_q;
	assign resync      = cur_q.now_us > (due_q + (64'(period_q) << 1));
	assign last_wr_val = resync ? cur_q.now_us : due_q;
	assign last_slot   = (CW'(i_q) + CW'(1)) == cnt_q;
	assign in_range    = XW'(cur_q.task_index) < XW'(cnt_q);
	assign full        = cnt_q == CW'(TASK_SLOTS);

	// next state and control
	always_comb begin
		state_d   = state_q;
		cmd_pop   = 1'b0;
		div_start = 1'b0;
		rd_en     = 1'b0;
		rd_addr   = '0;
		wr_reg    = 1'b0;
		wr_last   = 1'b0;
		adv       = 1'b0;
		emit      = 1'b0;
		res       = '0;
		res.last  = 1'b1;
		unique case (state_q)
			ptd_pkg::ST_IDLE: begin
				if (cmd_valid) begin
					cmd_pop = 1'b1;
					state_d = ptd_pkg::ST_DEC;
				end
			end
			ptd_pkg::ST_DEC: begin
				unique case (cur_q.op)
					ptd_pkg::OP_TICK: begin
						if (cnt_q == '0) begin
							state_d = ptd_pkg::ST_SUM;
						end else begin
							rd_en   = 1'b1;
							state_d = ptd_pkg::ST_ADD;
						end
					end
					ptd_pkg::OP_REG: begin
						res.kind = ptd_pkg::KIND_REGISTER;
						if (full || cur_q.zero_freq) begin
							if (out_free) begin
								emit    = 1'b1;
								state_d = ptd_pkg::ST_IDLE;
							end
						end else begin
							div_start = 1'b1;
							state_d   = ptd_pkg::ST_DIV;
						end
					end
					ptd_pkg::OP_RPT: begin
						res.kind = ptd_pkg::KIND_VERDICT;
						res.slot = cur_q.task_index;
						if (in_range) begin
							rd_en   = 1'b1;
							rd_addr = AW'(cur_q.task_index);
							state_d = ptd_pkg::ST_RPT;
						end else if (out_free) begin
							emit    = 1'b1;
							state_d = ptd_pkg::ST_IDLE;
						end
					end
					default: state_d = ptd_pkg::ST_IDLE;
				endcase
			end
			ptd_pkg::ST_DIV: begin
				res.kind     = ptd_pkg::KIND_REGISTER;
				res.slot     = 3'(cnt_q);
				res.accepted = 1'b1;
				if (div_done && out_free) begin
					wr_reg  = 1'b1;
					emit    = 1'b1;
					state_d = ptd_pkg::ST_IDLE;
				end
			end
			ptd_pkg::ST_ADD: begin
				state_d = ptd_pkg::ST_EVAL;
			end
			ptd_pkg::ST_EVAL: begin
				res.kind   = ptd_pkg::KIND_DISPATCH;
				res.slot   = 3'(i_q);
				res.lag_us = cur_q.now_us - due_q;
				res.last   = 1'b0;
				if (is_due) begin
					if (out_free) begin
						emit    = 1'b1;
						wr_last = 1'b1;
						adv     = 1'b1;
					end
				end else begin
					adv = 1'b1;
				end
				if (adv) begin
					if (last_slot) begin
						state_d = ptd_pkg::ST_SUM;
					end else begin
						rd_en   = 1'b1;
						rd_addr = i_q + AW'(1);
						state_d = ptd_pkg::ST_ADD;
					end
				end
			end
			ptd_pkg::ST_RPT: begin
				res.kind    = ptd_pkg::KIND_VERDICT;
				res.slot    = cur_q.task_index;
				res.overrun = cur_q.used_us > deadline_rd_q;
				if (out_free) begin
					emit    = 1'b1;
					state_d = ptd_pkg::ST_IDLE;
				end
			end
			ptd_pkg::ST_SUM: begin
				res.kind       = ptd_pkg::KIND_SUMMARY;
				res.wake_at_us = next_q;
				res.idle       = idle_q;
				if (out_free) begin
					emit    = 1'b1;
					state_d = ptd_pkg::ST_IDLE;
				end
			end
			default: state_d = ptd_pkg::ST_IDLE;
		endcase
	end

	// state and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ptd_pkg::ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (wr_reg) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// scan datapath
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cur_q <= cmd;
		end
		if (emit) begin
			out_q <= res;
		end
		if (state_q == ptd_pkg::ST_DEC) begin
			i_q    <= '0;
			next_q <= '1;
			idle_q <= 1'b1;
		end
		if (state_q == ptd_pkg::ST_ADD) begin
			due_q    <= last_rd_q + 64'(period_rd_q);
			period_q <= period_rd_q;
		end
		if (adv) begin
			i_q <= i_q + AW'(1);
			if (is_due) begin
				idle_q <= 1'b0;
			end else if (due_q < next_q) begin
				next_q <= due_q;
			end
		end
	end

	// table writes and registered reads
	always_ff @(posedge clk) begin
		if (wr_reg) begin
			period_mem[AW'(cnt_q)]   <= quotient;
			deadline_mem[AW'(cnt_q)] <= cur_q.budget_us;
		end
		if (rd_en) begin
			period_rd_q   <= period_mem[rd_addr];
			deadline_rd_q <= deadline_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_reg) begin
			last_mem[AW'(cnt_q)] <= cur_q.now_us;
		end else if (wr_last) begin
			last_mem[i_q] <= last_wr_val;
		end
		if (rd_en) begin
			last_rd_q <= last_mem[rd_addr];
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_q;

endmodule

`default_nettype wire
